// ----- sv/csl_pkg.sv -----
// package: codes, characters and defaults for the comment and quote span locator
`timescale 1ns / 1ps

package csl_pkg;

    localparam int OFFSET_WIDTH_DEFAULT = 24;
    localparam int COUNT_WIDTH_DEFAULT  = 16;
    localparam int LIMIT_WIDTH          = 16;
    localparam int APB_ADDR_WIDTH       = 3;
    localparam int APB_DATA_WIDTH       = 32;

    localparam logic [LIMIT_WIDTH-1:0] LIMIT_RESET = 16'hFFFF;

    // word index of a register (paddr[2])
    localparam logic REG_COMMENT_LIMIT = 1'b0;
    localparam logic REG_QUOTE_LIMIT   = 1'b1;

    localparam logic [7:0] CH_STAR      = 8'h2A;
    localparam logic [7:0] CH_NEWLINE   = 8'h0A;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_DIGIT_LO  = 8'h30;
    localparam logic [7:0] CH_DIGIT_HI  = 8'h39;

    localparam logic [1:0] KIND_COMMENT     = 2'd0;
    localparam logic [1:0] KIND_QUOTE       = 2'd1;
    localparam logic [1:0] KIND_COMMENT_OVF = 2'd2;
    localparam logic [1:0] KIND_QUOTE_OVF   = 2'd3;

    typedef enum logic [2:0] {
        MODE_OUTSIDE = 3'b001,
        MODE_COMMENT = 3'b010,
        MODE_QUOTE   = 3'b100
    } csl_mode_t;

    typedef struct packed {
        csl_mode_t  mode;
        logic       halted;
        logic [7:0] prev_byte;
    } csl_ctrl_t;

endpackage

// ----- sv/csl_ifs.sv -----
// interfaces: text byte channel and span result channel
`timescale 1ns / 1ps

interface csl_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       is_last;

    modport source (output valid, output text_byte, output is_last, input ready);
    modport sink (input valid, input text_byte, input is_last, output ready);
endinterface

interface csl_span_if #(
    parameter int OFFSET_WIDTH = csl_pkg::OFFSET_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH  = csl_pkg::COUNT_WIDTH_DEFAULT
);
    logic                    valid;
    logic                    ready;
    logic [1:0]              span_kind;
    logic [COUNT_WIDTH-1:0]  span_index;
    logic [OFFSET_WIDTH-1:0] start_offset;
    logic [OFFSET_WIDTH-1:0] end_offset;

    modport source (output valid, output span_kind, output span_index,
                    output start_offset, output end_offset, input ready);
    modport sink (input valid, input span_kind, input span_index,
                  input start_offset, input end_offset, output ready);
endinterface

// ----- sv/csl_scan.sv -----
// per-byte scan step: next state and span result for one text byte
`timescale 1ns / 1ps

module csl_scan #(
    parameter int OFFSET_WIDTH = csl_pkg::OFFSET_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH  = csl_pkg::COUNT_WIDTH_DEFAULT
) (
    input  csl_pkg::csl_ctrl_t                ctrl,
    input  logic [OFFSET_WIDTH-1:0]           offset,
    input  logic [OFFSET_WIDTH-1:0]           open_start,
    input  logic [COUNT_WIDTH-1:0]            comment_count,
    input  logic [COUNT_WIDTH-1:0]            quote_count,
    input  logic [7:0]                        text_byte,
    input  logic                              is_last,
    input  logic [csl_pkg::LIMIT_WIDTH-1:0]   comment_limit,
    input  logic [csl_pkg::LIMIT_WIDTH-1:0]   quote_limit,
    output csl_pkg::csl_ctrl_t                ctrl_next,
    output logic [OFFSET_WIDTH-1:0]           offset_next,
    output logic [OFFSET_WIDTH-1:0]           open_start_next,
    output logic [COUNT_WIDTH-1:0]            comment_count_next,
    output logic [COUNT_WIDTH-1:0]            quote_count_next,
    output logic                              res_valid,
    output logic [1:0]                        res_kind,
    output logic [COUNT_WIDTH-1:0]            res_index,
    output logic [OFFSET_WIDTH-1:0]           res_start
);

    localparam int CMP_WIDTH = (COUNT_WIDTH > csl_pkg::LIMIT_WIDTH) ?
                               COUNT_WIDTH : csl_pkg::LIMIT_WIDTH;

    logic prev_digit;
    logic prev_backslash;
    logic comment_full;
    logic quote_full;

    assign prev_digit     = (ctrl.prev_byte >= csl_pkg::CH_DIGIT_LO) &&
                            (ctrl.prev_byte <= csl_pkg::CH_DIGIT_HI);
    assign prev_backslash = (ctrl.prev_byte == csl_pkg::CH_BACKSLASH);
    assign comment_full   = CMP_WIDTH'(comment_count) >= CMP_WIDTH'(comment_limit);
    assign quote_full     = CMP_WIDTH'(quote_count) >= CMP_WIDTH'(quote_limit);

    always_comb
    begin
        ctrl_next           = ctrl;
        ctrl_next.prev_byte = text_byte;
        offset_next         = offset + OFFSET_WIDTH'(1);
        open_start_next     = open_start;
        comment_count_next  = comment_count;
        quote_count_next    = quote_count;
        res_valid           = 1'b0;
        res_kind            = csl_pkg::KIND_COMMENT;
        res_index           = comment_count;
        res_start           = open_start;

        if (!ctrl.halted)
        begin
            case (ctrl.mode)
                csl_pkg::MODE_COMMENT:
                begin
                    if ((text_byte == csl_pkg::CH_NEWLINE) || is_last)
                    begin
                        res_valid          = 1'b1;
                        comment_count_next = comment_count + COUNT_WIDTH'(1);
                        ctrl_next.mode     = csl_pkg::MODE_OUTSIDE;
                    end
                end
                csl_pkg::MODE_QUOTE:
                begin
                    if ((text_byte == csl_pkg::CH_DQUOTE) && !prev_backslash)
                    begin
                        res_valid        = 1'b1;
                        res_kind         = csl_pkg::KIND_QUOTE;
                        res_index        = quote_count;
                        quote_count_next = quote_count + COUNT_WIDTH'(1);
                        ctrl_next.mode   = csl_pkg::MODE_OUTSIDE;
                    end
                end
                csl_pkg::MODE_OUTSIDE:
                begin
                    if (text_byte == csl_pkg::CH_STAR)
                    begin
                        if (comment_full)
                        begin
                            res_valid        = 1'b1;
                            res_kind         = csl_pkg::KIND_COMMENT_OVF;
                            res_start        = offset;
                            ctrl_next.halted = 1'b1;
                        end
                        else
                        begin
                            ctrl_next.mode  = csl_pkg::MODE_COMMENT;
                            open_start_next = offset;
                        end
                    end
                    else if ((text_byte == csl_pkg::CH_DQUOTE) && !prev_digit)
                    begin
                        if (quote_full)
                        begin
                            res_valid        = 1'b1;
                            res_kind         = csl_pkg::KIND_QUOTE_OVF;
                            res_index        = quote_count;
                            res_start        = offset;
                            ctrl_next.halted = 1'b1;
                        end
                        else
                        begin
                            ctrl_next.mode  = csl_pkg::MODE_QUOTE;
                            open_start_next = offset;
                        end
                    end
                end
                default:
                begin
                    ctrl_next.mode = csl_pkg::MODE_OUTSIDE;
                end
            endcase
        end

        // end of file: next byte starts a fresh scan
        if (is_last)
        begin
            ctrl_next.mode      = csl_pkg::MODE_OUTSIDE;
            ctrl_next.halted    = 1'b0;
            ctrl_next.prev_byte = 8'h00;
            offset_next         = '0;
            open_start_next     = '0;
            comment_count_next  = '0;
            quote_count_next    = '0;
        end
    end

endmodule

// ----- sv/comment_quote_span_locator.sv -----
// top level: comment and quoted-string span locator with apb limit registers
// a span beat is in the output register from the cycle after its closing byte is taken
// throughput: one text byte per cycle while no output beat is held, set by the scan state update;
// a held output beat stalls input until it is taken
// reset: asynchronous, active low; scan state clears, both limits return to 65535
// no clearing pass follows reset
`timescale 1ns / 1ps

module comment_quote_span_locator #(
    parameter int OFFSET_WIDTH = csl_pkg::OFFSET_WIDTH_DEFAULT,
    parameter int COUNT_WIDTH  = csl_pkg::COUNT_WIDTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    csl_byte_if.sink                            byte_in,
    csl_span_if.source                          span_out,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [csl_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [csl_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [csl_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                pready
);

    csl_pkg::csl_ctrl_t              ctrl_reg;
    csl_pkg::csl_ctrl_t              ctrl_next;
    logic [OFFSET_WIDTH-1:0]         offset_reg;
    logic [OFFSET_WIDTH-1:0]         offset_next;
    logic [OFFSET_WIDTH-1:0]         open_start_reg;
    logic [OFFSET_WIDTH-1:0]         open_start_next;
    logic [COUNT_WIDTH-1:0]          comment_count_reg;
    logic [COUNT_WIDTH-1:0]          comment_count_next;
    logic [COUNT_WIDTH-1:0]          quote_count_reg;
    logic [COUNT_WIDTH-1:0]          quote_count_next;
    logic [csl_pkg::LIMIT_WIDTH-1:0] comment_limit_reg;
    logic [csl_pkg::LIMIT_WIDTH-1:0] quote_limit_reg;

    logic                            res_valid;
    logic [1:0]                      res_kind;
    logic [COUNT_WIDTH-1:0]          res_index;
    logic [OFFSET_WIDTH-1:0]         res_start;

    logic                            out_valid_reg;
    logic [1:0]                      out_kind_reg;
    logic [COUNT_WIDTH-1:0]          out_index_reg;
    logic [OFFSET_WIDTH-1:0]         out_start_reg;
    logic [OFFSET_WIDTH-1:0]         out_end_reg;

    logic                            in_fire;
    logic                            cfg_write;

    assign byte_in.ready = !out_valid_reg || span_out.ready;
    assign in_fire       = byte_in.valid && byte_in.ready;

    csl_scan #(
        .OFFSET_WIDTH (OFFSET_WIDTH),
        .COUNT_WIDTH  (COUNT_WIDTH)
    ) u_scan (
        .ctrl               (ctrl_reg),
        .offset             (offset_reg),
        .open_start         (open_start_reg),
        .comment_count      (comment_count_reg),
        .quote_count        (quote_count_reg),
        .text_byte          (byte_in.text_byte),
        .is_last            (byte_in.is_last),
        .comment_limit      (comment_limit_reg),
        .quote_limit        (quote_limit_reg),
        .ctrl_next          (ctrl_next),
        .offset_next        (offset_next),
        .open_start_next    (open_start_next),
        .comment_count_next (comment_count_next),
        .quote_count_next   (quote_count_next),
        .res_valid          (res_valid),
        .res_kind           (res_kind),
        .res_index          (res_index),
        .res_start          (res_start)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.mode      <= csl_pkg::MODE_OUTSIDE;
            ctrl_reg.halted    <= 1'b0;
            ctrl_reg.prev_byte <= 8'h00;
            offset_reg         <= '0;
            open_start_reg     <= '0;
            comment_count_reg  <= '0;
            quote_count_reg    <= '0;
        end
        else if (in_fire)
        begin
            ctrl_reg          <= ctrl_next;
            offset_reg        <= offset_next;
            open_start_reg    <= open_start_next;
            comment_count_reg <= comment_count_next;
            quote_count_reg   <= quote_count_next;
        end
    end

    // output register: loads on a beat that closes a span or overflows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= res_valid;
        end
        else if (span_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && res_valid)
        begin
            out_kind_reg  <= res_kind;
            out_index_reg <= res_index;
            out_start_reg <= res_start;
            out_end_reg   <= offset_reg;
        end
    end

    assign span_out.valid        = out_valid_reg;
    assign span_out.span_kind    = out_kind_reg;
    assign span_out.span_index   = out_index_reg;
    assign span_out.start_offset = out_start_reg;
    assign span_out.end_offset   = out_end_reg;

    // apb: word address in paddr[2], low bits ignored
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comment_limit_reg <= csl_pkg::LIMIT_RESET;
            quote_limit_reg   <= csl_pkg::LIMIT_RESET;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                csl_pkg::REG_COMMENT_LIMIT: comment_limit_reg <= pwdata[csl_pkg::LIMIT_WIDTH-1:0];
                csl_pkg::REG_QUOTE_LIMIT:   quote_limit_reg   <= pwdata[csl_pkg::LIMIT_WIDTH-1:0];
                default:                    comment_limit_reg <= comment_limit_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            csl_pkg::REG_COMMENT_LIMIT: prdata = csl_pkg::APB_DATA_WIDTH'(comment_limit_reg);
            csl_pkg::REG_QUOTE_LIMIT:   prdata = csl_pkg::APB_DATA_WIDTH'(quote_limit_reg);
            default:                    prdata = '0;
        endcase
    end

endmodule

// ----- sv/csl_checker.sv -----
// port-level checker for the span locator, bound to the top level
`timescale 1ns / 1ps

module csl_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_kind,
    input logic       overflow_same_offset,
    input logic       pready
);

    // a held beat must stay until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("span beat dropped while stalled");

    // a stalled output blocks new text bytes
    a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while output stalled");

    // a new span beat needs a text byte taken the cycle before
    a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_valid && in_ready))
        else $error("span beat without a text byte");

    // overflow beats point at one byte
    a_ovf_offsets: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind[1] |-> overflow_same_offset)
        else $error("overflow start and end differ");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready low");

endmodule

bind comment_quote_span_locator csl_checker u_csl_checker (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (byte_in.valid),
    .in_ready             (byte_in.ready),
    .out_valid            (span_out.valid),
    .out_ready            (span_out.ready),
    .out_kind             (span_out.span_kind),
    .overflow_same_offset (span_out.start_offset == span_out.end_offset),
    .pready               (pready)
);
